// ----- hdl/seven_segment_scan_driver_top_assert.svh -----
// ---------------------------------------------------------------------------
// seven segment scan driver assertion macros
// concurrent checks, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SSSD_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define SSSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SSSD_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define SSSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/sssd_pkg.sv -----
// ---------------------------------------------------------------------------
// sssd_pkg
// shared types, constants and glyph table of the scan driver
// ---------------------------------------------------------------------------
`default_nettype none

package sssd_pkg;

   localparam int NUM_DIGITS  = 3;
   localparam int VALUE_W     = 10;
   localparam int DIGIT_W     = 4;
   localparam int REM_W       = 7;
   localparam int SEG_W       = 8;
   localparam int EN_W        = 3;
   localparam int DIGIT_MAX   = 9;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [VALUE_W-1:0] MAX_VALUE   = 10'd999;
   localparam logic [SEG_W-1:0]   SEG_ALL_OFF = 8'hFF;
   localparam logic [EN_W-1:0]    EN_ALL_OFF  = 3'b111;
   localparam logic [EN_W-1:0]    EN_HUNDREDS = 3'b110;
   localparam logic [EN_W-1:0]    EN_TENS     = 3'b101;
   localparam logic [EN_W-1:0]    EN_ONES     = 3'b011;

   localparam logic [SEG_W-1:0] GLYPH [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   typedef enum logic [1:0] {
      PHASE_HUNDREDS = 2'd0,
      PHASE_TENS     = 2'd1,
      PHASE_ONES     = 2'd2
   } scan_phase_type;

   typedef struct packed {
      logic               load;
      logic [DIGIT_W-1:0] hundreds;
      logic [REM_W-1:0]   remainder;
   } queue_entry_type;

   typedef struct packed {
      logic            push;
      queue_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   function automatic logic [SEG_W-1:0] glyph_lines(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] pattern;
      pattern = (int'(digit) <= DIGIT_MAX) ? GLYPH[digit] : '0;
      return ~pattern & SEG_ALL_OFF;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/sssd_if.sv -----
// ---------------------------------------------------------------------------
// sssd channel interfaces
// request and response channels with valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface sssd_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [sssd_pkg::VALUE_W-1:0] value;
   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

interface sssd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [sssd_pkg::SEG_W-1:0] segment_lines;
   logic [sssd_pkg::EN_W-1:0]  digit_enables;
   modport source (output valid, output segment_lines, output digit_enables, input ready);
   modport sink (input valid, input segment_lines, input digit_enables, output ready);
endinterface

`default_nettype wire

// ----- hdl/seven_segment_scan_driver_top.sv -----
// ---------------------------------------------------------------------------
// seven_segment_scan_driver_top
// three digit multiplexed seven segment driver with leading zero blanking
// ---------------------------------------------------------------------------
// One item is taken every clock cycle while the queue is not full; its result
// is offered after the front stage writes the two-entry queue at the accepting
// edge and the back stage, once its output is free, moves it from the queue head
// into the output registers. A load item (mode 1) saturates the value to 999 and
// stores its digits, returning the unchanged outputs; a tick item (mode 0) lights
// the digit of the current scan phase, blanking leading zeros, and advances the
// phase. Segment lines and digit enables are active low. A result holds until
// taken, and while it waits the queue takes up to two more items before the input stalls.
`default_nettype none

module seven_segment_scan_driver_top (
   input  wire logic  clock,
   input  wire logic  reset,
   sssd_req_if.sink   req_ch,
   sssd_rsp_if.source rsp_ch
);

   sssd_pkg::queue_push_type push;
   sssd_pkg::queue_head_type head;
   logic                     queue_full;
   logic                     pop;

   sssd_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   sssd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   sssd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- hdl/sssd_front.sv -----
// ---------------------------------------------------------------------------
// sssd_front
// accepts items, saturates load values and splits off the hundreds digit
// ---------------------------------------------------------------------------
`default_nettype none

module sssd_front (
   sssd_req_if.sink                 req_ch,
   input  wire logic                queue_full,
   output sssd_pkg::queue_push_type push
);

   logic [sssd_pkg::VALUE_W-1:0] sat;
   logic [sssd_pkg::VALUE_W-1:0] base;
   logic [sssd_pkg::DIGIT_W-1:0] hund;

   always_comb begin
      sat  = (req_ch.value > sssd_pkg::MAX_VALUE) ? sssd_pkg::MAX_VALUE : req_ch.value;
      hund = '0;
      base = '0;
      for (int k = 1; k <= sssd_pkg::DIGIT_MAX; k++) begin
         if (sat >= sssd_pkg::VALUE_W'(k * 100)) begin
            hund = sssd_pkg::DIGIT_W'(k);
            base = sssd_pkg::VALUE_W'(k * 100);
         end
      end
   end

   assign req_ch.ready          = !queue_full;
   assign push.push             = req_ch.valid && !queue_full;
   assign push.entry.load       = req_ch.mode;
   assign push.entry.hundreds   = hund;
   assign push.entry.remainder  = sssd_pkg::REM_W'(sat - base);

endmodule

`default_nettype wire

// ----- hdl/sssd_queue.sv -----
// ---------------------------------------------------------------------------
// sssd_queue
// short fifo between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module sssd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  sssd_pkg::queue_push_type push,
   input  wire logic                pop,
   output sssd_pkg::queue_head_type head,
   output logic                     full
);

   sssd_pkg::queue_entry_type       store_ff [sssd_pkg::QUEUE_DEPTH];
   logic [sssd_pkg::PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sssd_pkg::PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sssd_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                            do_push, do_pop;

   assign full     = (count_ff == sssd_pkg::CNT_W'(sssd_pkg::QUEUE_DEPTH));
   assign do_push  = push.push && !full;
   assign do_pop   = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = store_ff[rd_ptr_ff];

   function automatic logic [sssd_pkg::PTR_W-1:0] next_ptr(input logic [sssd_pkg::PTR_W-1:0] p);
      return (p == sssd_pkg::PTR_W'(sssd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/sssd_back.sv -----
// ---------------------------------------------------------------------------
// sssd_back
// holds the digits and scan state, executes loads and ticks
// ---------------------------------------------------------------------------
`default_nettype none
`include "seven_segment_scan_driver_top_assert.svh"

module sssd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  sssd_pkg::queue_head_type head,
   output logic                     pop,
   sssd_rsp_if.source               rsp_ch
);

   logic [sssd_pkg::DIGIT_W-1:0] hundreds_ff, hundreds_in;
   logic [sssd_pkg::DIGIT_W-1:0] tens_ff, tens_in;
   logic [sssd_pkg::DIGIT_W-1:0] ones_ff, ones_in;
   sssd_pkg::scan_phase_type     phase_ff, phase_in;
   logic [sssd_pkg::SEG_W-1:0]   segment_ff, segment_in;
   logic [sssd_pkg::EN_W-1:0]    enable_ff, enable_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sssd_pkg::DIGIT_W-1:0] tens_split;
   logic [sssd_pkg::REM_W-1:0]   tens_base;

   assign pop = head.valid && (!rsp_valid_ff || rsp_ch.ready);

   // tens and ones out of the remainder below one hundred
   always_comb begin
      tens_split = '0;
      tens_base  = '0;
      for (int k = 1; k <= sssd_pkg::DIGIT_MAX; k++) begin
         if (head.entry.remainder >= sssd_pkg::REM_W'(k * 10)) begin
            tens_split = sssd_pkg::DIGIT_W'(k);
            tens_base  = sssd_pkg::REM_W'(k * 10);
         end
      end
   end

   always_comb begin
      hundreds_in  = hundreds_ff;
      tens_in      = tens_ff;
      ones_in      = ones_ff;
      phase_in     = phase_ff;
      segment_in   = segment_ff;
      enable_in    = enable_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (head.entry.load) begin
            hundreds_in = head.entry.hundreds;
            tens_in     = tens_split;
            ones_in     = sssd_pkg::DIGIT_W'(head.entry.remainder - tens_base);
         end else begin
            enable_in = sssd_pkg::EN_ALL_OFF;
            case (phase_ff)
               sssd_pkg::PHASE_HUNDREDS: begin
                  if (hundreds_ff != '0) begin
                     segment_in = sssd_pkg::glyph_lines(hundreds_ff);
                     enable_in  = sssd_pkg::EN_HUNDREDS;
                  end
               end
               sssd_pkg::PHASE_TENS: begin
                  if (hundreds_ff != '0 || tens_ff != '0) begin
                     segment_in = sssd_pkg::glyph_lines(tens_ff);
                     enable_in  = sssd_pkg::EN_TENS;
                  end
               end
               sssd_pkg::PHASE_ONES: begin
                  segment_in = sssd_pkg::glyph_lines(ones_ff);
                  enable_in  = sssd_pkg::EN_ONES;
               end
               default: begin
                  enable_in = sssd_pkg::EN_ALL_OFF;
               end
            endcase
            if (int'(phase_ff) >= sssd_pkg::NUM_DIGITS - 1) begin
               phase_in = sssd_pkg::PHASE_HUNDREDS;
            end else begin
               phase_in = sssd_pkg::scan_phase_type'(phase_ff + 2'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hundreds_ff  <= '0;
         tens_ff      <= '0;
         ones_ff      <= '0;
         phase_ff     <= sssd_pkg::PHASE_HUNDREDS;
         segment_ff   <= '0;
         enable_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hundreds_ff  <= hundreds_in;
         tens_ff      <= tens_in;
         ones_ff      <= ones_in;
         phase_ff     <= phase_in;
         segment_ff   <= segment_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.segment_lines = segment_ff;
   assign rsp_ch.digit_enables = enable_ff;

   `SSSD_ASSERT_ALWAYS(a_phase_range, clock, reset, int'(phase_ff) < sssd_pkg::NUM_DIGITS)
   `SSSD_ASSERT_ALWAYS(a_digit_range, clock, reset, hundreds_ff <= 4'd9 && tens_ff <= 4'd9 && ones_ff <= 4'd9)
   `SSSD_ASSERT_NEXT(a_tick_one_lit, clock, reset, pop && !head.entry.load, $countones(enable_ff) >= 2)
   `SSSD_ASSERT_NEXT(a_load_keeps_out, clock, reset, pop && head.entry.load, $stable(segment_ff) && $stable(enable_ff) && $stable(phase_ff))

endmodule

`default_nettype wire
